@@ design/mcd_pkg.sv @@
// Shared types, constants and the Morse decode ROM for the Morse code decoder.
`default_nettype none

package mcd_pkg;

    // Input item kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_EOL  = 1'b1;

    // Character bytes of interest
    localparam logic [7:0] BYTE_DOT   = 8'd46;
    localparam logic [7:0] BYTE_DASH  = 8'd45;
    localparam logic [7:0] BYTE_SPACE = 8'd32;

    // ASCII space emitted on a word gap
    localparam logic [6:0] ASCII_SPACE = 7'd32;

    // Longest pattern held in the ROM
    localparam int unsigned ROM_MAX_LEN = 6;
    localparam int unsigned ROM_IDX_W   = ROM_MAX_LEN + 1;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_byte;
    } item_t;

    typedef struct packed {
        logic [6:0] ascii_out;
        logic       char_valid;
        logic       end_of_line;
    } result_t;

    // ROM index is a leading one followed by the symbols, dash = 1, oldest first.
    // Zero means no character.
    function automatic logic [6:0] decode_rom(input logic [ROM_IDX_W-1:0] idx);
        logic [6:0] ch;
        case (idx)
            7'd5:    ch = 7'h41; // A
            7'd24:   ch = 7'h42; // B
            7'd26:   ch = 7'h43; // C
            7'd12:   ch = 7'h44; // D
            7'd2:    ch = 7'h45; // E
            7'd18:   ch = 7'h46; // F
            7'd14:   ch = 7'h47; // G
            7'd16:   ch = 7'h48; // H
            7'd4:    ch = 7'h49; // I
            7'd23:   ch = 7'h4A; // J
            7'd13:   ch = 7'h4B; // K
            7'd20:   ch = 7'h4C; // L
            7'd7:    ch = 7'h4D; // M
            7'd6:    ch = 7'h4E; // N
            7'd15:   ch = 7'h4F; // O
            7'd22:   ch = 7'h50; // P
            7'd29:   ch = 7'h51; // Q
            7'd10:   ch = 7'h52; // R
            7'd8:    ch = 7'h53; // S
            7'd3:    ch = 7'h54; // T
            7'd9:    ch = 7'h55; // U
            7'd17:   ch = 7'h56; // V
            7'd11:   ch = 7'h57; // W
            7'd25:   ch = 7'h58; // X
            7'd27:   ch = 7'h59; // Y
            7'd28:   ch = 7'h5A; // Z
            7'd63:   ch = 7'h30; // 0
            7'd47:   ch = 7'h31; // 1
            7'd39:   ch = 7'h32; // 2
            7'd35:   ch = 7'h33; // 3
            7'd33:   ch = 7'h34; // 4
            7'd32:   ch = 7'h35; // 5
            7'd48:   ch = 7'h36; // 6
            7'd56:   ch = 7'h37; // 7
            7'd60:   ch = 7'h38; // 8
            7'd62:   ch = 7'h39; // 9
            7'd85:   ch = 7'h2E; // full stop
            7'd115:  ch = 7'h2C; // comma
            7'd76:   ch = 7'h3F; // question mark
            7'd94:   ch = 7'h27; // apostrophe
            7'd107:  ch = 7'h21; // exclamation mark
            7'd50:   ch = 7'h2F; // slash
            7'd54:   ch = 7'h28; // open bracket
            7'd109:  ch = 7'h29; // close bracket
            7'd40:   ch = 7'h26; // ampersand
            7'd120:  ch = 7'h3A; // colon
            7'd106:  ch = 7'h3B; // semicolon
            7'd49:   ch = 7'h3D; // equals
            7'd42:   ch = 7'h2B; // plus
            7'd97:   ch = 7'h2D; // hyphen
            7'd77:   ch = 7'h5F; // underscore
            7'd82:   ch = 7'h22; // double quote
            7'd90:   ch = 7'h40; // at sign
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

@@ design/morse_code_decoder.sv @@
// Top level of the Morse code decoder.
`default_nettype none

// Decodes a line of Morse text given one byte per transfer: dots and dashes build
// a pattern, a first space decodes it through the fixed International Morse table
// and a second space in a row gives an ASCII space; an end-of-line item flushes the
// pattern and always returns one result marked end_of_line. Patterns that are
// unknown, empty, hold a bad byte or are too long return nothing (except at end of
// line). The block takes one item every clock cycle unless the result output stalls; each
// item passes an input register, then one table lookup with the pattern register update,
// and then a result register that presents its result.

module morse_code_decoder #(
    parameter int unsigned MAX_SYMBOLS = 6
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_kind,
    input  wire logic [7:0] s_char_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [6:0]      m_ascii_out,
    output logic            m_char_valid,
    output logic            m_end_of_line
);

    logic             out_free;
    logic             fire;
    logic             emit;
    mcd_pkg::item_t   item;
    mcd_pkg::result_t result;

    mcd_in_stage u_in (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_char_byte (s_char_byte),
        .out_free    (out_free),
        .fire        (fire),
        .item        (item)
    );

    mcd_core #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .emit    (emit),
        .result  (result)
    );

    mcd_out_stage u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (fire),
        .emit          (emit),
        .result        (result),
        .out_free      (out_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ascii_out   (m_ascii_out),
        .m_char_valid  (m_char_valid),
        .m_end_of_line (m_end_of_line)
    );

endmodule

`default_nettype wire

@@ design/mcd_in_stage.sv @@
// Input register stage of the Morse code decoder.
`default_nettype none

module mcd_in_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic          s_kind,
    input  wire logic [7:0]    s_char_byte,
    input  wire logic          out_free,
    output logic               fire,
    output mcd_pkg::item_t     item
);

    logic           valid_reg;
    logic           valid_next;
    mcd_pkg::item_t item_reg;
    logic           load;

    // Held item moves on whenever the result register can take it
    assign fire    = valid_reg && out_free;
    assign s_ready = !valid_reg || out_free;
    assign load    = s_valid && s_ready;
    assign item    = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (fire) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg.kind      <= s_kind;
            item_reg.char_byte <= s_char_byte;
        end
    end

endmodule

`default_nettype wire

@@ design/mcd_core.sv @@
// Pattern state and table decode of the Morse code decoder.
`default_nettype none

module mcd_core #(
    parameter int unsigned MAX_SYMBOLS = 6
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           fire,
    input  wire mcd_pkg::item_t item,
    output logic                emit,
    output mcd_pkg::result_t    result
);

    localparam int unsigned LEN_W = $clog2(MAX_SYMBOLS + 1);
    localparam int unsigned BITS_W = mcd_pkg::ROM_MAX_LEN;
    localparam int unsigned IDX_W = mcd_pkg::ROM_IDX_W;

    logic [BITS_W-1:0] bits_reg,    bits_next;
    logic [LEN_W-1:0]  len_reg,     len_next;
    logic              invalid_reg, invalid_next;
    logic              space_reg,   space_next;

    logic              too_long;
    logic [IDX_W-1:0]  rom_idx;
    logic [6:0]        decoded;
    logic              is_dot;
    logic              is_dash;

    // Table lookup of the pattern held so far
    assign too_long = len_reg > LEN_W'(mcd_pkg::ROM_MAX_LEN);
    assign rom_idx  = IDX_W'(IDX_W'(1) << len_reg[2:0]) | IDX_W'(bits_reg);
    assign decoded  = (invalid_reg || too_long) ? 7'd0 : mcd_pkg::decode_rom(rom_idx);

    assign is_dot  = item.char_byte == mcd_pkg::BYTE_DOT;
    assign is_dash = item.char_byte == mcd_pkg::BYTE_DASH;

    // Next state and result for one item
    always_comb begin
        bits_next    = bits_reg;
        len_next     = len_reg;
        invalid_next = invalid_reg;
        space_next   = space_reg;
        emit         = 1'b0;
        result       = '0;
        if (item.kind == mcd_pkg::KIND_EOL) begin
            // flush: always one result, closes the line
            emit               = 1'b1;
            result.ascii_out   = decoded;
            result.char_valid  = decoded != 7'd0;
            result.end_of_line = 1'b1;
            bits_next          = '0;
            len_next           = '0;
            invalid_next       = 1'b0;
            space_next         = 1'b0;
        end else if (item.char_byte == mcd_pkg::BYTE_SPACE) begin
            if (space_reg) begin
                // word gap
                space_next        = 1'b0;
                emit              = 1'b1;
                result.ascii_out  = mcd_pkg::ASCII_SPACE;
                result.char_valid = 1'b1;
            end else begin
                emit              = decoded != 7'd0;
                result.ascii_out  = decoded;
                result.char_valid = 1'b1;
                bits_next         = '0;
                len_next          = '0;
                invalid_next      = 1'b0;
                space_next        = 1'b1;
            end
        end else begin
            space_next = 1'b0;
            if (is_dot || is_dash) begin
                if (len_reg >= LEN_W'(MAX_SYMBOLS)) begin
                    invalid_next = 1'b1;
                end else begin
                    bits_next = {bits_reg[BITS_W-2:0], is_dash};
                    len_next  = len_reg + LEN_W'(1);
                end
            end else begin
                invalid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_reg    <= '0;
            len_reg     <= '0;
            invalid_reg <= 1'b0;
            space_reg   <= 1'b0;
        end else if (fire) begin
            bits_reg    <= bits_next;
            len_reg     <= len_next;
            invalid_reg <= invalid_next;
            space_reg   <= space_next;
        end
    end

    // Checks
    a_eol_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.kind == mcd_pkg::KIND_EOL |-> emit && result.end_of_line)
        else $error("end of line item gave no closing result");

    a_eol_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.kind == mcd_pkg::KIND_EOL
        |=> len_reg == '0 && !invalid_reg && !space_reg)
        else $error("pattern state not cleared after end of line");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(MAX_SYMBOLS))
        else $error("pattern length beyond maximum");

    a_empty_only_eol: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && !result.char_valid |-> result.end_of_line)
        else $error("result without character outside end of line");

endmodule

`default_nettype wire

@@ design/mcd_out_stage.sv @@
// Result register stage of the Morse code decoder.
`default_nettype none

module mcd_out_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             fire,
    input  wire logic             emit,
    input  wire mcd_pkg::result_t result,
    output logic                  out_free,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [6:0]            m_ascii_out,
    output logic                  m_char_valid,
    output logic                  m_end_of_line
);

    logic             valid_reg;
    logic             valid_next;
    mcd_pkg::result_t result_reg;

    // Free when empty or the waiting result transfers this cycle
    assign out_free = !valid_reg || m_ready;

    always_comb begin
        if (fire) begin
            valid_next = emit;
        end else begin
            valid_next = valid_reg && !m_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && emit) begin
            result_reg <= result;
        end
    end

    assign m_valid       = valid_reg;
    assign m_ascii_out   = result_reg.ascii_out;
    assign m_char_valid  = result_reg.char_valid;
    assign m_end_of_line = result_reg.end_of_line;

endmodule

`default_nettype wire

@@ dv/morse_code_decoder_test.sv @@
// Self-checking testbench for the Morse code decoder: directed lines, then random Morse text.
`default_nettype none

module morse_code_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_SYMBOLS   = 6;
    localparam int          RANDOM_ITEMS  = 1025;
    localparam int          IDLE_PERCENT  = 18;
    localparam int          STALL_LIMIT   = 2000;
    localparam int          DRAIN_CYCLES  = 16;
    // Window of transfers during which neither side idles
    localparam int          CALM_FROM     = 400;
    localparam int          CALM_TO       = 600;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic       s_kind        = 1'b0;
    logic [7:0] s_char_byte   = 8'd0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic [6:0] m_ascii_out;
    logic       m_char_valid;
    logic       m_end_of_line;

    mcd_pkg::item_t   pending_items[$];
    mcd_pkg::result_t expected_chars[$];
    string            code_list[$];
    logic [6:0]       morse_lut[128];

    // Decoder state as the testbench tracks it
    logic [5:0] sym_bits  = '0;
    logic [3:0] sym_count = '0;
    logic       sym_bad   = 1'b0;
    logic       gap_armed = 1'b0;

    int items_taken = 0;
    int errors      = 0;
    int chars_seen  = 0;
    int gaps_seen   = 0;
    int lines_seen  = 0;

    morse_code_decoder #(
        .MAX_SYMBOLS(MAX_SYMBOLS)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_char_byte  (s_char_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ascii_out  (m_ascii_out),
        .m_char_valid (m_char_valid),
        .m_end_of_line(m_end_of_line)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    task automatic flag_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        errors++;
    endtask

    // Enter one code into the lookup table: leading one, then dash = 1, oldest first
    task automatic add_code(input string code, input logic [7:0] ch);
        logic [6:0] idx;
        idx = 7'd1;
        for (int i = 0; i < code.len(); i++) begin
            idx = {idx[5:0], code[i] == "-"};
        end
        morse_lut[idx] = ch[6:0];
        code_list.push_back(code);
    endtask

    function automatic logic [6:0] lookup_pattern();
        logic [6:0] idx;
        if (sym_bad || sym_count > 4'd6) begin
            return 7'd0;
        end
        idx = (7'd1 << sym_count) | {1'b0, sym_bits};
        return morse_lut[idx];
    endfunction

    task automatic clear_pattern();
        sym_bits  = '0;
        sym_count = '0;
        sym_bad   = 1'b0;
    endtask

    // Update the tracked state for one accepted item and queue what it should produce
    task automatic decode_step(input mcd_pkg::item_t it);
        mcd_pkg::result_t res;
        logic [6:0]       ch;
        if (it.kind == mcd_pkg::KIND_EOL) begin
            ch              = lookup_pattern();
            res.ascii_out   = ch;
            res.char_valid  = (ch != 7'd0);
            res.end_of_line = 1'b1;
            expected_chars.push_back(res);
            clear_pattern();
            gap_armed = 1'b0;
        end else if (it.char_byte == mcd_pkg::BYTE_SPACE) begin
            if (gap_armed) begin
                gap_armed       = 1'b0;
                res.ascii_out   = mcd_pkg::ASCII_SPACE;
                res.char_valid  = 1'b1;
                res.end_of_line = 1'b0;
                expected_chars.push_back(res);
            end else begin
                ch = lookup_pattern();
                clear_pattern();
                gap_armed = 1'b1;
                if (ch != 7'd0) begin
                    res.ascii_out   = ch;
                    res.char_valid  = 1'b1;
                    res.end_of_line = 1'b0;
                    expected_chars.push_back(res);
                end
            end
        end else begin
            gap_armed = 1'b0;
            if (it.char_byte == mcd_pkg::BYTE_DOT || it.char_byte == mcd_pkg::BYTE_DASH) begin
                if (sym_count >= MAX_SYMBOLS) begin
                    sym_bad = 1'b1;
                end else begin
                    sym_bits  = {sym_bits[4:0], it.char_byte == mcd_pkg::BYTE_DASH};
                    sym_count = sym_count + 4'd1;
                end
            end else begin
                sym_bad = 1'b1;
            end
        end
    endtask

    task automatic push_item(input logic kind, input logic [7:0] b);
        mcd_pkg::item_t it;
        it.kind      = kind;
        it.char_byte = b;
        pending_items.push_back(it);
    endtask

    task automatic push_code(input string code);
        for (int i = 0; i < code.len(); i++) begin
            push_item(mcd_pkg::KIND_CHAR,
                      (code[i] == "-") ? mcd_pkg::BYTE_DASH : mcd_pkg::BYTE_DOT);
        end
    endtask

    function automatic logic calm_window();
        return items_taken >= CALM_FROM && items_taken < CALM_TO;
    endfunction

    // Input driver: payload held until the transfer, random gaps between items
    always @(posedge aclk) begin
        mcd_pkg::item_t nxt;
        mcd_pkg::item_t cur;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                cur.kind      = s_kind;
                cur.char_byte = s_char_byte;
                decode_step(cur);
                items_taken++;
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() > 0
                        && (calm_window() || $urandom_range(99) >= IDLE_PERCENT)) begin
                    nxt = pending_items.pop_front();
                    s_valid     <= 1'b1;
                    s_kind      <= nxt.kind;
                    s_char_byte <= nxt.char_byte;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each transfer with the oldest expected character
    always @(posedge aclk) begin
        mcd_pkg::result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    flag_error($sformatf("unexpected result ascii=%0d valid=%0b eol=%0b",
                                         m_ascii_out, m_char_valid, m_end_of_line));
                end else begin
                    want = expected_chars.pop_front();
                    if (m_ascii_out !== want.ascii_out)
                        flag_error($sformatf("ascii_out %0d, expected %0d",
                                             m_ascii_out, want.ascii_out));
                    if (m_char_valid !== want.char_valid)
                        flag_error($sformatf("char_valid %0b, expected %0b",
                                             m_char_valid, want.char_valid));
                    if (m_end_of_line !== want.end_of_line)
                        flag_error($sformatf("end_of_line %0b, expected %0b",
                                             m_end_of_line, want.end_of_line));
                    if (want.end_of_line)
                        lines_seen++;
                    else if (want.ascii_out == mcd_pkg::ASCII_SPACE)
                        gaps_seen++;
                    else
                        chars_seen++;
                end
            end
            m_ready <= calm_window() || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Stimulus, reset, watchdog and end of run
    initial begin
        int   total_items;
        int   stall;
        int   pick;
        int   n;
        logic timed_out;

        for (int i = 0; i < 128; i++) begin
            morse_lut[i] = 7'd0;
        end
        add_code(".-", "A");     add_code("-...", "B");   add_code("-.-.", "C");
        add_code("-..", "D");    add_code(".", "E");      add_code("..-.", "F");
        add_code("--.", "G");    add_code("....", "H");   add_code("..", "I");
        add_code(".---", "J");   add_code("-.-", "K");    add_code(".-..", "L");
        add_code("--", "M");     add_code("-.", "N");     add_code("---", "O");
        add_code(".--.", "P");   add_code("--.-", "Q");   add_code(".-.", "R");
        add_code("...", "S");    add_code("-", "T");      add_code("..-", "U");
        add_code("...-", "V");   add_code(".--", "W");    add_code("-..-", "X");
        add_code("-.--", "Y");   add_code("--..", "Z");
        add_code("-----", "0");  add_code(".----", "1");  add_code("..---", "2");
        add_code("...--", "3");  add_code("....-", "4");  add_code(".....", "5");
        add_code("-....", "6");  add_code("--...", "7");  add_code("---..", "8");
        add_code("----.", "9");
        add_code(".-.-.-", "."); add_code("--..--", ","); add_code("..--..", "?");
        add_code(".----.", "'"); add_code("-.-.--", "!"); add_code("-..-.", "/");
        add_code("-.--.", "(");  add_code("-.--.-", ")"); add_code(".-...", "&");
        add_code("---...", ":"); add_code("-.-.-.", ";"); add_code("-...-", "=");
        add_code(".-.-.", "+");  add_code("-....-", "-"); add_code("..--.-", "_");
        add_code(".-..-.", "\""); add_code(".--.-.", "@");

        // Directed: letter, word gap, third space, longest code, flush paths, bad bytes
        push_code(".-");
        push_item(mcd_pkg::KIND_CHAR, mcd_pkg::BYTE_SPACE);
        push_item(mcd_pkg::KIND_CHAR, mcd_pkg::BYTE_SPACE);
        push_item(mcd_pkg::KIND_CHAR, mcd_pkg::BYTE_SPACE);
        push_code(".--.-.");
        push_item(mcd_pkg::KIND_CHAR, mcd_pkg::BYTE_SPACE);
        push_code("-----");
        push_item(mcd_pkg::KIND_EOL, 8'hFF);
        push_item(mcd_pkg::KIND_EOL, 8'h00);
        push_code("-.");
        push_item(mcd_pkg::KIND_CHAR, 8'h00);
        push_item(mcd_pkg::KIND_CHAR, mcd_pkg::BYTE_SPACE);
        push_code("-------");
        push_item(mcd_pkg::KIND_CHAR, mcd_pkg::BYTE_SPACE);
        push_item(mcd_pkg::KIND_CHAR, 8'hFF);
        push_item(mcd_pkg::KIND_EOL, mcd_pkg::BYTE_DOT);

        // Random: mostly real Morse text, some noise, runs of symbols and stray flushes
        n = pending_items.size() + RANDOM_ITEMS;
        while (pending_items.size() < n) begin
            pick = $urandom_range(99);
            if (pick < 68) begin
                push_code(code_list[$urandom_range(code_list.size() - 1)]);
                if ($urandom_range(5) == 0) begin
                    push_item(mcd_pkg::KIND_EOL, 8'($urandom_range(255)));
                end else begin
                    push_item(mcd_pkg::KIND_CHAR, mcd_pkg::BYTE_SPACE);
                    if ($urandom_range(3) == 0)
                        push_item(mcd_pkg::KIND_CHAR, mcd_pkg::BYTE_SPACE);
                end
            end else if (pick < 76) begin
                push_item(mcd_pkg::KIND_EOL, 8'($urandom_range(255)));
            end else if (pick < 86) begin
                repeat ($urandom_range(1, 8)) begin
                    push_item(mcd_pkg::KIND_CHAR,
                              $urandom_range(1) ? mcd_pkg::BYTE_DASH : mcd_pkg::BYTE_DOT);
                end
                push_item(mcd_pkg::KIND_CHAR, mcd_pkg::BYTE_SPACE);
            end else if (pick < 94) begin
                push_item(mcd_pkg::KIND_CHAR, 8'($urandom_range(255)));
            end else begin
                push_item(mcd_pkg::KIND_CHAR, mcd_pkg::BYTE_SPACE);
            end
        end
        total_items = pending_items.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Run until every item is taken and every expected character has arrived
        stall     = 0;
        timed_out = 1'b0;
        while (!timed_out && !(items_taken == total_items && expected_chars.size() == 0)) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall = 0;
            else
                stall++;
            if (stall >= STALL_LIMIT)
                timed_out = 1'b1;
        end

        if (!timed_out) begin
            repeat (DRAIN_CYCLES) @(posedge aclk);
            if (expected_chars.size() != 0)
                flag_error($sformatf("%0d expected results never arrived",
                                     expected_chars.size()));
            $display("Sent %0d items (%0d directed-and-random), checked %0d characters,",
                     items_taken, total_items, chars_seen);
            $display("%0d word gaps and %0d line ends; %0d mismatches.",
                     gaps_seen, lines_seen, errors);
        end else begin
            $display("Watchdog: no transfer for %0d cycles, %0d of %0d items taken",
                     STALL_LIMIT, items_taken, total_items);
        end

        if (!timed_out && errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
design/mcd_pkg.sv
design/mcd_in_stage.sv
design/mcd_core.sv
design/mcd_out_stage.sv
design/morse_code_decoder.sv
dv/morse_code_decoder_test.sv
